### rtl/md5_pkg.sv
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [63:0] digest_low;
		logic [63:0] digest_high;
	} digest_t;

	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       fold;
		logic [5:0] rnd;
	} rnd_ctl_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LEN_OFFSET = 6'd56;
	localparam logic [5:0]  LAST_OFFSET = 6'd63;

	localparam logic [4:0] ROUND_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

	function automatic logic [31:0] round_k(input logic [5:0] r);
		return ROUND_K[r];
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] r);
		return ROUND_S[{r[5:4], r[1:0]}];
	endfunction

	// message word index used by round r
	function automatic logic [3:0] round_g(input logic [5:0] r);
		logic [3:0] i;
		logic [3:0] g;
		i = r[3:0];
		case (r[5:4])
			2'd0: g = i;
			2'd1: g = 4'((i << 2) + i + 4'd1);
			2'd2: g = 4'((i << 1) + i + 4'd5);
			2'd3: g = 4'((i << 3) - i);
			default: g = i;
		endcase
		return g;
	endfunction

endpackage

### rtl/md5_message_digest.sv
// MD5 digest engine.
// msg channel (valid/ready): one transfer per item; data_byte is appended to the
// message when byte_valid is set, end_of_message closes the message after it.
// digest channel (valid/ready): one transfer per finished message, digest bytes
// 0..7 in digest_low and 8..15 in digest_high, byte 0 in the low bits.
// Bytes are taken one per cycle while msg_ready is high. Completing a 64-byte
// block drops msg_ready while a load state primes the block memory read, 64
// rounds run (one per cycle through the shared round unit, words read from
// the block memory's read port, apart from its write port) and a fold state
// adds into the chaining words. On end_of_message the pad and length bytes
// are written one per cycle, then one or two blocks are compressed; after the
// last fold the digest is registered once the output register is free.
// The digest sits in an output register; new message bytes are taken while it
// waits, and only the next digest waits for the receiver to take it.
// Reset (arst_n low) loads the initial chaining words and clears the count;
// after each digest the engine returns to that state by itself.
module md5_message_digest import md5_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	output logic    msg_ready,
	input  msg_t    msg,
	output logic    digest_valid,
	input  logic    digest_ready,
	output digest_t digest
);

	typedef enum logic [2:0] {
		S_FILL,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_FOLD,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [5:0]    ptr_q;
	logic [60:0]   cnt_q;
	logic [5:0]    rnd_q;
	logic          fin_q, first_q, len_q;
	logic          digest_valid_q;
	digest_t       digest_q;

	logic [31:0]   blk_mem [16];
	logic [31:0]   rd_word_q;
	logic [3:0]    rd_addr;
	logic          take, wr_en, len_now, out_free;
	logic [7:0]    wr_byte, pad_byte;
	logic [63:0]   bit_len;
	logic [5:0]    rnd_nx;
	logic [127:0]  chain;
	rnd_ctl_t      ctl;

	assign msg_ready = (state_q == S_FILL);
	assign take = msg_valid && msg_ready;
	assign out_free = !digest_valid_q || digest_ready;
	assign rnd_nx = 6'(rnd_q + 6'd1);
	assign bit_len = {cnt_q, 3'b000};
	assign len_now = len_q || (ptr_q == LEN_OFFSET && !first_q);

	always_comb begin
		if (first_q)
			pad_byte = PAD_BYTE;
		else if (len_now)
			pad_byte = bit_len[{ptr_q[2:0], 3'b000} +: 8];
		else
			pad_byte = 8'h00;
	end

	assign wr_en = (take && msg.byte_valid) || (state_q == S_PAD);
	assign wr_byte = (state_q == S_PAD) ? pad_byte : msg.data_byte;
	assign rd_addr = round_g((state_q == S_ROUND) ? rnd_nx : 6'd0);

	always_ff @(posedge clk) begin
		if (wr_en)
			blk_mem[ptr_q[5:2]][{ptr_q[1:0], 3'b000} +: 8] <= wr_byte;
		rd_word_q <= blk_mem[rd_addr];
	end

	always_comb begin
		ctl.init = (state_q == S_DONE) && out_free;
		ctl.load = (state_q == S_LOAD);
		ctl.step = (state_q == S_ROUND);
		ctl.fold = (state_q == S_FOLD);
		ctl.rnd = rnd_q;
	end

	md5_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.word   (rd_word_q),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			ptr_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			first_q <= 1'b0;
			len_q <= 1'b0;
			digest_valid_q <= 1'b0;
			digest_q <= '0;
		end else begin
			if (digest_valid_q && digest_ready)
				digest_valid_q <= 1'b0;
			case (state_q)
				S_FILL: begin
					if (take) begin
						if (msg.byte_valid) begin
							ptr_q <= 6'(ptr_q + 6'd1);
							cnt_q <= 61'(cnt_q + 61'd1);
						end
						if (msg.end_of_message) begin
							fin_q <= 1'b1;
							first_q <= 1'b1;
						end
						if (msg.byte_valid && ptr_q == LAST_OFFSET)
							state_q <= S_LOAD;
						else if (msg.end_of_message)
							state_q <= S_PAD;
					end
				end
				S_PAD: begin
					ptr_q <= 6'(ptr_q + 6'd1);
					first_q <= 1'b0;
					if (len_now)
						len_q <= 1'b1;
					if (ptr_q == LAST_OFFSET)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					rnd_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_nx;
					if (rnd_q == 6'd63)
						state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (!fin_q)
						state_q <= S_FILL;
					else if (len_q)
						state_q <= S_DONE;
					else
						state_q <= S_PAD;
				end
				S_DONE: begin
					if (out_free) begin
						digest_q.digest_low <= chain[63:0];
						digest_q.digest_high <= chain[127:64];
						digest_valid_q <= 1'b1;
						fin_q <= 1'b0;
						len_q <= 1'b0;
						cnt_q <= '0;
						ptr_q <= '0;
						state_q <= S_FILL;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest = digest_q;

endmodule

### rtl/md5_round.sv
module md5_round import md5_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rnd_ctl_t     ctl,
	input  logic [31:0]  word,
	output logic [127:0] chain
);

	logic [31:0] cv_q [4];
	logic [31:0] a_q, b_q, c_q, d_q, ak_q;
	logic [31:0] f, sum;
	logic [63:0] dbl;
	logic [31:0] new_b;

	always_comb begin
		case (ctl.rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		sum = ak_q + f + word;
		dbl = {sum, sum} << round_s(ctl.rnd);
		new_b = b_q + dbl[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= IV_A;
			cv_q[1] <= IV_B;
			cv_q[2] <= IV_C;
			cv_q[3] <= IV_D;
		end else if (ctl.init) begin
			cv_q[0] <= IV_A;
			cv_q[1] <= IV_B;
			cv_q[2] <= IV_C;
			cv_q[3] <= IV_D;
		end else if (ctl.fold) begin
			cv_q[0] <= cv_q[0] + a_q;
			cv_q[1] <= cv_q[1] + b_q;
			cv_q[2] <= cv_q[2] + c_q;
			cv_q[3] <= cv_q[3] + d_q;
		end
	end

	// a plus the next round's constant is registered during the current round
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
			ak_q <= cv_q[0] + round_k(6'd0);
		end else if (ctl.step) begin
			a_q <= d_q;
			b_q <= new_b;
			c_q <= b_q;
			d_q <= c_q;
			ak_q <= d_q + round_k(6'(ctl.rnd + 6'd1));
		end
	end

	assign chain = {cv_q[3], cv_q[2], cv_q[1], cv_q[0]};

endmodule

### rtl/md5_checker.sv
module md5_checker import md5_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    msg_valid,
	input logic    msg_ready,
	input msg_t    msg,
	input logic    digest_valid,
	input logic    digest_ready,
	input digest_t digest
);

	// stalled digest holds
	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest))
		else $error("digest changed while stalled");

	// closing transfer makes the engine busy
	a_eom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg.end_of_message |=> !msg_ready)
		else $error("msg_ready high after end of message");

	// an empty transfer changes nothing
	a_idle_item: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && !msg.byte_valid && !msg.end_of_message |=> msg_ready)
		else $error("empty transfer stalled the engine");

	// a digest only appears at the end of a busy period
	a_digest_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> !$past(msg_ready))
		else $error("digest appeared while accepting bytes");

endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);

### tb/md5_message_digest_tb.sv
`timescale 1ns / 1ps

module md5_message_digest_tb import md5_pkg::*;;

	localparam int HOLD_CYCLES = 1500;
	localparam int HOLD_AT_RESULT = 3;
	localparam int TAIL_CYCLES = 250;

	localparam logic [31:0] CHAIN_IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

	localparam int MD5_SHIFT [4][4] = '{
		'{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    msg_valid = 1'b0;
	logic    msg_ready;
	msg_t    msg = '0;
	logic    digest_valid;
	logic    digest_ready = 1'b0;
	digest_t digest;

	md5_message_digest u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	logic [31:0] md5_chain [4];
	logic [7:0]  md5_block [64];
	logic [63:0] md5_bytes;

	msg_t    msg_queue [$];
	digest_t digest_expected [$];

	int stim_items;
	int stim_msgs;
	int gap_left;
	bit calm_tx;
	bit calm_rx;
	int ready_wait;
	int wait_n;
	int results_seen;
	int errors;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic md5_clear();
		for (int i = 0; i < 4; i++)
			md5_chain[i] = CHAIN_IV[i];
		for (int i = 0; i < 64; i++)
			md5_block[i] = 8'h00;
		md5_bytes = '0;
	endtask

	task automatic md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, sum;
		int g, s;
		for (int i = 0; i < 16; i++)
			w[i] = {md5_block[4*i+3], md5_block[4*i+2], md5_block[4*i+1], md5_block[4*i]};
		a = md5_chain[0];
		b = md5_chain[1];
		c = md5_chain[2];
		d = md5_chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			s = MD5_SHIFT[r / 16][r % 4];
			sum = a + f + MD5_K[r] + w[g];
			t = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
			a = t;
		end
		md5_chain[0] = md5_chain[0] + a;
		md5_chain[1] = md5_chain[1] + b;
		md5_chain[2] = md5_chain[2] + c;
		md5_chain[3] = md5_chain[3] + d;
	endtask

	task automatic md5_absorb(input logic [7:0] v);
		logic [5:0] off;
		off = md5_bytes[5:0];
		md5_block[off] = v;
		md5_bytes = md5_bytes + 64'd1;
		if (off == 6'd63)
			md5_compress();
	endtask

	// update the running digest with one accepted transfer
	task automatic md5_predict(input msg_t m);
		logic [63:0] bit_len;
		digest_t d;
		if (m.byte_valid)
			md5_absorb(m.data_byte);
		if (m.end_of_message) begin
			bit_len = md5_bytes << 3;
			md5_absorb(8'h80);
			while (md5_bytes[5:0] != 6'd56)
				md5_absorb(8'h00);
			for (int i = 0; i < 8; i++)
				md5_absorb(bit_len[8*i +: 8]);
			d.digest_low = {md5_chain[1], md5_chain[0]};
			d.digest_high = {md5_chain[3], md5_chain[2]};
			digest_expected.push_back(d);
			md5_clear();
		end
	endtask

	task automatic queue_item(input logic [7:0] data, input logic bv, input logic eom);
		msg_t m;
		m.data_byte = data;
		m.byte_valid = bv;
		m.end_of_message = eom;
		msg_queue.push_back(m);
		if (bv || eom)
			stim_items++;
	endtask

	// one message of len bytes, with idle transfers sprinkled in
	task automatic queue_message(input int len);
		bit close_on_byte;
		close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0)
				queue_item(8'($urandom), 1'b0, 1'b0);
			queue_item(8'($urandom), 1'b1, close_on_byte && (k == len - 1));
		end
		if (!close_on_byte)
			queue_item(8'($urandom), 1'b0, 1'b1);
		stim_msgs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid <= 1'b0;
			msg <= '0;
			gap_left <= 0;
			md5_clear();
		end else begin
			if (msg_valid && msg_ready) begin
				md5_predict(msg);
				if ($urandom_range(0, 39) == 0)
					calm_tx <= !calm_tx;
			end
			if (!msg_valid || msg_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					msg_valid <= 1'b0;
				end else if (msg_queue.size() != 0) begin
					msg <= msg_queue.pop_front();
					msg_valid <= 1'b1;
					gap_left <= calm_tx ? 0 : $urandom_range(0, 5);
				end else begin
					msg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_ready <= 1'b0;
			ready_wait <= 0;
		end else begin
			if (digest_valid && digest_ready) begin
				if (digest_expected.size() == 0) begin
					$error("unexpected digest transfer: %h %h", digest.digest_low,
						digest.digest_high);
					errors++;
				end else begin
					digest_t exp_d;
					exp_d = digest_expected.pop_front();
					if (digest.digest_low !== exp_d.digest_low) begin
						$error("digest_low: expected %h, got %h", exp_d.digest_low,
							digest.digest_low);
						errors++;
					end
					if (digest.digest_high !== exp_d.digest_high) begin
						$error("digest_high: expected %h, got %h", exp_d.digest_high,
							digest.digest_high);
						errors++;
					end
				end
				results_seen++;
				if ($urandom_range(0, 9) == 0)
					calm_rx <= !calm_rx;
				// long hold-off so the output stage backs up into the input
				if (results_seen == HOLD_AT_RESULT)
					wait_n = HOLD_CYCLES;
				else
					wait_n = calm_rx ? 0 : $urandom_range(0, 5);
				ready_wait <= wait_n;
				digest_ready <= (wait_n == 0);
			end else if (ready_wait != 0) begin
				ready_wait <= ready_wait - 1;
				digest_ready <= (ready_wait == 1);
			end else begin
				digest_ready <= 1'b1;
			end
		end
	end

	initial begin
		int pick;
		int len;
		int edge_lens [10];
		edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		md5_clear();

		queue_item(8'hA5, 1'b0, 1'b0);
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'h00, 1'b1, 1'b1);
		queue_item(8'h61, 1'b1, 1'b0);
		queue_item(8'h62, 1'b1, 1'b0);
		queue_item(8'h63, 1'b1, 1'b1);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(8'h5A, 1'b0, 1'b1);
		queue_item(8'hFF, 1'b0, 1'b0);
		queue_item(8'hFF, 1'b0, 1'b1);
		queue_message(12);

		while (stim_items < 1500 || stim_msgs < 20) begin
			pick = $urandom_range(0, 19);
			if (pick < 6)
				len = $urandom_range(0, 8);
			else if (pick < 12)
				len = edge_lens[$urandom_range(0, 9)];
			else if (pick < 19)
				len = $urandom_range(0, 130);
			else
				len = $urandom_range(150, 300);
			queue_message(len);
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (msg_queue.size() != 0 || msg_valid)
			@(posedge clk);
		while (digest_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/md5_pkg.sv
rtl/md5_round.sv
rtl/md5_message_digest.sv
rtl/md5_checker.sv
tb/md5_message_digest_tb.sv
